// File: src/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and constants
// Fixed-point widths, register indexes and rounding constants for the
// quaternion point rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

    localparam int QW   = 16;            // quaternion component, Q2.14
    localparam int CW   = 32;            // coordinate, Q16.16
    localparam int MW   = 35;            // matrix element, Q.28
    localparam int HW   = CW / 2;        // coordinate half word
    localparam int PHW  = MW + HW;       // element * signed high half
    localparam int PLW  = MW + HW + 1;   // element * unsigned low half
    localparam int SHW  = PHW + 2;       // sum of three high products
    localparam int SLW  = PLW + 2;       // sum of three low products
    localparam int TW   = SHW + HW + 1;  // full Q.44 dot product
    localparam int FRAC = 28;            // Q.44 -> Q16.16 shift
    localparam int QRW  = TW - FRAC;     // rounded value before clamping
    localparam int RIW  = 2;             // register index width

    typedef logic signed [QW-1:0]   quat_t;
    typedef logic signed [2*QW-1:0] qprod_t;
    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [MW-1:0]   melem_t;
    typedef logic signed [SHW-1:0]  sum_hi_t;
    typedef logic signed [SLW-1:0]  sum_lo_t;

    typedef struct packed {
        melem_t m0;
        melem_t m1;
        melem_t m2;
    } mrow_t;

    typedef enum logic [RIW-1:0] {
        REG_QUAT_X = 2'd0,
        REG_QUAT_Y = 2'd1,
        REG_QUAT_Z = 2'd2,
        REG_QUAT_W = 2'd3
    } reg_index_t;

    localparam quat_t  QUAT_ONE = 16'sd16384;
    localparam melem_t ONE_Q28  = 35'sh0_1000_0000;

    localparam logic signed [TW-1:0] ROUND_HALF =
        {{(TW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

    localparam logic signed [QRW-1:0] SAT_HI = QRW'(64'sd2147483647);
    localparam logic signed [QRW-1:0] SAT_LO = QRW'(-64'sd2147483648);

endpackage

`default_nettype wire

// File: src/qvr_matrix.sv
// ----------------------------------------------------------------------------
// qvr_matrix: quaternion registers and rotation matrix
// Holds the four components and rebuilds the Q.28 matrix in two
// registered steps: component products, then the nine elements.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_matrix
    import qvr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire reg_index_t wr_index,
    input  wire quat_t      wr_data,
    output mrow_t           row0,
    output mrow_t           row1,
    output mrow_t           row2
);

    quat_t  qx_reg, qy_reg, qz_reg, qw_reg;
    qprod_t sxx_reg, syy_reg, szz_reg, sxy_reg, sxz_reg, syz_reg;
    qprod_t swx_reg, swy_reg, swz_reg;
    mrow_t  row0_reg, row1_reg, row2_reg;
    mrow_t  row0_next, row1_next, row2_next;

    function automatic melem_t diag_term(input qprod_t a, input qprod_t b);
        diag_term = ONE_Q28 - ((MW'(a) + MW'(b)) <<< 1);
    endfunction

    function automatic melem_t sum_term(input qprod_t a, input qprod_t b);
        sum_term = (MW'(a) + MW'(b)) <<< 1;
    endfunction

    function automatic melem_t diff_term(input qprod_t a, input qprod_t b);
        diff_term = (MW'(a) - MW'(b)) <<< 1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= QUAT_ONE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_QUAT_X: qx_reg <= wr_data;
                REG_QUAT_Y: qy_reg <= wr_data;
                REG_QUAT_Z: qz_reg <= wr_data;
                REG_QUAT_W: qw_reg <= wr_data;
                default:    qw_reg <= qw_reg;
            endcase
        end
    end

    // products of the identity are all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sxx_reg <= '0;
            syy_reg <= '0;
            szz_reg <= '0;
            sxy_reg <= '0;
            sxz_reg <= '0;
            syz_reg <= '0;
            swx_reg <= '0;
            swy_reg <= '0;
            swz_reg <= '0;
        end
        else
        begin
            sxx_reg <= qx_reg * qx_reg;
            syy_reg <= qy_reg * qy_reg;
            szz_reg <= qz_reg * qz_reg;
            sxy_reg <= qx_reg * qy_reg;
            sxz_reg <= qx_reg * qz_reg;
            syz_reg <= qy_reg * qz_reg;
            swx_reg <= qw_reg * qx_reg;
            swy_reg <= qw_reg * qy_reg;
            swz_reg <= qw_reg * qz_reg;
        end
    end

    always_comb
    begin
        row0_next.m0 = diag_term(syy_reg, szz_reg);
        row0_next.m1 = diff_term(sxy_reg, swz_reg);
        row0_next.m2 = sum_term(sxz_reg, swy_reg);
        row1_next.m0 = sum_term(sxy_reg, swz_reg);
        row1_next.m1 = diag_term(sxx_reg, szz_reg);
        row1_next.m2 = diff_term(syz_reg, swx_reg);
        row2_next.m0 = diff_term(sxz_reg, swy_reg);
        row2_next.m1 = sum_term(syz_reg, swx_reg);
        row2_next.m2 = diag_term(sxx_reg, syy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg <= '{m0: ONE_Q28, m1: '0, m2: '0};
            row1_reg <= '{m0: '0, m1: ONE_Q28, m2: '0};
            row2_reg <= '{m0: '0, m1: '0, m2: ONE_Q28};
        end
        else
        begin
            row0_reg <= row0_next;
            row1_reg <= row1_next;
            row2_reg <= row2_next;
        end
    end

    assign row0 = row0_reg;
    assign row1 = row1_reg;
    assign row2 = row2_reg;

endmodule

`default_nettype wire

// File: src/qvr_row.sv
// ----------------------------------------------------------------------------
// qvr_row: one matrix row times the point
// Splits each coordinate into a signed high and an unsigned low half,
// registers the six partial products, then the two exact sums.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_row
    import qvr_pkg::*;
(
    input  wire logic   clk,
    input  wire mrow_t  row,
    input  wire coord_t cx,
    input  wire coord_t cy,
    input  wire coord_t cz,
    output sum_hi_t     sum_hi,
    output sum_lo_t     sum_lo
);

    logic signed [PHW-1:0] ph0_reg, ph1_reg, ph2_reg;
    logic signed [PLW-1:0] pl0_reg, pl1_reg, pl2_reg;
    sum_hi_t               sum_hi_reg;
    sum_lo_t               sum_lo_reg;

    always_ff @(posedge clk)
    begin
        ph0_reg <= $signed(row.m0) * $signed(cx[CW-1:HW]);
        ph1_reg <= $signed(row.m1) * $signed(cy[CW-1:HW]);
        ph2_reg <= $signed(row.m2) * $signed(cz[CW-1:HW]);
        pl0_reg <= $signed(row.m0) * $signed({1'b0, cx[HW-1:0]});
        pl1_reg <= $signed(row.m1) * $signed({1'b0, cy[HW-1:0]});
        pl2_reg <= $signed(row.m2) * $signed({1'b0, cz[HW-1:0]});
    end

    always_ff @(posedge clk)
    begin
        sum_hi_reg <= SHW'(ph0_reg) + SHW'(ph1_reg) + SHW'(ph2_reg);
        sum_lo_reg <= SLW'(pl0_reg) + SLW'(pl1_reg) + SLW'(pl2_reg);
    end

    assign sum_hi = sum_hi_reg;
    assign sum_lo = sum_lo_reg;

endmodule

`default_nettype wire

// File: src/qvr_sat.sv
// ----------------------------------------------------------------------------
// qvr_sat: rounding and clamping
// Joins the half-word sums, rounds Q.44 to Q16.16 with ties upward and
// clamps to the signed 32-bit range into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_sat
    import qvr_pkg::*;
(
    input  wire logic    clk,
    input  wire sum_hi_t sum_hi,
    input  wire sum_lo_t sum_lo,
    output coord_t       rot
);

    logic signed [TW-1:0]  total;
    logic signed [QRW-1:0] rounded;
    coord_t                rot_reg;
    coord_t                rot_next;

    always_comb
    begin
        total   = (TW'(sum_hi) <<< HW) + TW'(sum_lo) + ROUND_HALF;
        rounded = total[TW-1:FRAC];
        priority if (rounded > SAT_HI)
            rot_next = SAT_HI[CW-1:0];
        else if (rounded < SAT_LO)
            rot_next = SAT_LO[CW-1:0];
        else
            rot_next = rounded[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
    end

    assign rot = rot_reg;

endmodule

`default_nettype wire

// File: src/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate: point rotation by a Q2.14 quaternion
// Rotates Q16.16 points by the matrix of the quaternion in four registers.
// ----------------------------------------------------------------------------
// Usage:
//   Registers quat_x, quat_y, quat_z, quat_w are written through wr_en,
//   wr_index and wr_data (low 16 bits used). The matrix is rebuilt from
//   the registers through the product and row registers after a write;
//   a request may follow in the cycle after the write.
//   A request is taken when start is high and busy is low. busy is never
//   raised: one point can enter every cycle.
//   Each result sits on rot_x/rot_y/rot_z for one cycle with done high.
//   Throughput: one point per cycle.
//   Stages: input register, alignment register, partial products, row
//   sums, rounding and clamping into the output register.
//   Reset clears the pipeline valid flags and loads the identity.
//   The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire logic [RIW-1:0] wr_index,
    input  wire logic [QW-1:0]  wr_data,
    input  wire logic           start,
    output logic                busy,
    input  wire logic [CW-1:0]  coord_x,
    input  wire logic [CW-1:0]  coord_y,
    input  wire logic [CW-1:0]  coord_z,
    output logic                done,
    output logic [CW-1:0]       rot_x,
    output logic [CW-1:0]       rot_y,
    output logic [CW-1:0]       rot_z
);

    logic    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic    accept;
    coord_t  cx1_reg, cy1_reg, cz1_reg;
    coord_t  cx2_reg, cy2_reg, cz2_reg;
    mrow_t   row0, row1, row2;
    sum_hi_t sum_hi0, sum_hi1, sum_hi2;
    sum_lo_t sum_lo0, sum_lo1, sum_lo2;
    coord_t  rx, ry, rz;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // second coordinate stage lines the point up with the rebuilt matrix
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx1_reg <= coord_x;
            cy1_reg <= coord_y;
            cz1_reg <= coord_z;
        end
        cx2_reg <= cx1_reg;
        cy2_reg <= cy1_reg;
        cz2_reg <= cz1_reg;
    end

    qvr_matrix u_matrix
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (reg_index_t'(wr_index)),
        .wr_data  (wr_data),
        .row0     (row0),
        .row1     (row1),
        .row2     (row2)
    );

    qvr_row u_row0
    (
        .clk    (clk),
        .row    (row0),
        .cx     (cx2_reg),
        .cy     (cy2_reg),
        .cz     (cz2_reg),
        .sum_hi (sum_hi0),
        .sum_lo (sum_lo0)
    );

    qvr_row u_row1
    (
        .clk    (clk),
        .row    (row1),
        .cx     (cx2_reg),
        .cy     (cy2_reg),
        .cz     (cz2_reg),
        .sum_hi (sum_hi1),
        .sum_lo (sum_lo1)
    );

    qvr_row u_row2
    (
        .clk    (clk),
        .row    (row2),
        .cx     (cx2_reg),
        .cy     (cy2_reg),
        .cz     (cz2_reg),
        .sum_hi (sum_hi2),
        .sum_lo (sum_lo2)
    );

    qvr_sat u_sat_x
    (
        .clk    (clk),
        .sum_hi (sum_hi0),
        .sum_lo (sum_lo0),
        .rot    (rx)
    );

    qvr_sat u_sat_y
    (
        .clk    (clk),
        .sum_hi (sum_hi1),
        .sum_lo (sum_lo1),
        .rot    (ry)
    );

    qvr_sat u_sat_z
    (
        .clk    (clk),
        .sum_hi (sum_hi2),
        .sum_lo (sum_lo2),
        .rot    (rz)
    );

    assign done  = v5_reg;
    assign rot_x = rx;
    assign rot_y = ry;
    assign rot_z = rz;

    // every request yields a result with done high
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("request did not produce a result after five cycles");

    // no result without a matching earlier request
    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result without a matching request");

    // valid flags step one stage per cycle
    a_pipe_flags : assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> $past(v2_reg) && $past(v1_reg, 2))
        else $error("valid flag lost inside the pipeline");

endmodule

`default_nettype wire
